// ===== hdl/abd_pkg.sv =====
// ============================================================================
// abd_pkg - shared definitions for the ARGB box downsampler
// Widths, register indexes, reset values, handshake payload types and the
// reciprocal table that turns the block-area division into a multiply.
// ============================================================================
package abd_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SOURCE_WIDTH_DEF = 4096;
    localparam int MAX_FACTOR_DEF       = 16;

    // Fixed frame limits
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = 12;
    localparam int DIM_W        = 13;
    localparam int FACTOR_W     = 5;
    localparam int CMP_W        = DIM_W + 2;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd1;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd480;

    // Pixel and channel-sum layout
    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int NUM_CH = 4;
    localparam int SUM_W  = 16;
    localparam int LINE_W = NUM_CH * SUM_W;

    // Reciprocal multiply: quotient = (sum * recip) >> RECIP_SHIFT
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // Per-pixel control decided at accept time
    typedef struct packed {
        logic bypass;     // factor of one: pixel goes straight out
        logic acc;        // pixel lies inside a whole block
        logic first;      // top-left pixel of its block: start a fresh sum
        logic emit;       // pixel produces a result
        logic row_end;
        logic frame_end;
    } abd_ctl_t;

    // Result item
    typedef struct packed {
        logic [PIX_W-1:0] averaged_pixel;
        logic             row_end;
        logic             frame_end;
    } abd_res_t;

    // ceil(2^24 / f^2): exact floor division of any 16-bit sum by f^2
    function automatic logic [RECIP_W-1:0] abd_recip(input logic [FACTOR_W-1:0] factor);
        logic [RECIP_W-1:0] r;
        case (factor)
            5'd2:    r = 23'd4194304;
            5'd3:    r = 23'd1864136;
            5'd4:    r = 23'd1048576;
            5'd5:    r = 23'd671089;
            5'd6:    r = 23'd466034;
            5'd7:    r = 23'd342393;
            5'd8:    r = 23'd262144;
            5'd9:    r = 23'd207127;
            5'd10:   r = 23'd167773;
            5'd11:   r = 23'd138655;
            5'd12:   r = 23'd116509;
            5'd13:   r = 23'd99274;
            5'd14:   r = 23'd85599;
            5'd15:   r = 23'd74566;
            5'd16:   r = 23'd65536;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/abd_if.sv =====
// ============================================================================
// abd_if - valid/ready channels of the ARGB box downsampler
// Source pixel channel and result channel, each with source and sink views.
// ============================================================================
interface abd_pix_if;
    logic                        valid;
    logic                        ready;
    logic [abd_pkg::PIX_W-1:0]   source_pixel;

    modport source (output valid, output source_pixel, input ready);
    modport sink   (input valid, input source_pixel, output ready);
endinterface

interface abd_res_if;
    logic                        valid;
    logic                        ready;
    logic [abd_pkg::PIX_W-1:0]   averaged_pixel;
    logic                        row_end;
    logic                        frame_end;

    modport source (output valid, output averaged_pixel, output row_end,
                    output frame_end, input ready);
    modport sink   (input valid, input averaged_pixel, input row_end,
                    input frame_end, output ready);
endinterface

// ===== hdl/abd_ram.sv =====
// ============================================================================
// abd_ram - generic single-clock RAM
// One write port, one read port, read data registered.
// ============================================================================
module abd_ram #(
    parameter int WIDTH = abd_pkg::LINE_W,
    parameter int DEPTH = abd_pkg::MAX_SOURCE_WIDTH_DEF / 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/abd_ctrl.sv =====
// ============================================================================
// abd_ctrl - configuration registers and raster position tracking
// Holds the three registers, walks the source position and block position,
// and classifies each accepted pixel for the accumulate path.
// ============================================================================
module abd_ctrl #(
    parameter int MAX_SOURCE_WIDTH = abd_pkg::MAX_SOURCE_WIDTH_DEF,
    parameter int MAX_FACTOR       = abd_pkg::MAX_FACTOR_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [abd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [abd_pkg::DIM_W-1:0]              cfg_data,
    input  logic                                   advance,
    output abd_pkg::abd_ctl_t                      ctl,
    output logic [$clog2(MAX_SOURCE_WIDTH/2)-1:0]  addr,
    output logic [abd_pkg::FACTOR_W-1:0]           factor
);

    localparam int DIM_MAX = (1 << abd_pkg::DIM_W) - 1;
    localparam int WCAP    = (MAX_SOURCE_WIDTH < DIM_MAX) ? MAX_SOURCE_WIDTH : DIM_MAX;
    localparam int COL_W   = $clog2(WCAP);
    localparam int BC_W    = $clog2(MAX_SOURCE_WIDTH / 2);
    localparam int SUB_W   = $clog2(MAX_FACTOR);
    localparam int FW      = abd_pkg::FACTOR_W;
    localparam int CW      = abd_pkg::CMP_W;

    logic [FW-1:0]                factor_reg, factor_next;
    logic [abd_pkg::DIM_W-1:0]    width_reg, width_next;
    logic [abd_pkg::DIM_W-1:0]    height_reg, height_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [abd_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [SUB_W-1:0]             sub_col_reg, sub_col_next;
    logic [SUB_W-1:0]             sub_row_reg, sub_row_next;
    logic [BC_W-1:0]              bc_reg, bc_next;

    logic [FW-1:0]                f_eff;
    logic [abd_pkg::DIM_W-1:0]    w_eff;
    logic [abd_pkg::DIM_W-1:0]    h_eff;
    logic [CW-1:0]                col_x, row_x, sc_x, sr_x, f_x, w_x, h_x;
    logic                         cfg_hit;
    logic                         last_col, last_row;
    logic                         col_in, row_in, in_block;
    logic                         blk_last, blk_row_end, blk_frame_end;

    // Clamp the registers to their working ranges
    always_comb
    begin
        if (factor_reg == '0)
            f_eff = FW'(1);
        else if (factor_reg > FW'(MAX_FACTOR))
            f_eff = FW'(MAX_FACTOR);
        else
            f_eff = factor_reg;

        if (width_reg == '0)
            w_eff = abd_pkg::DIM_W'(1);
        else if (width_reg > abd_pkg::DIM_W'(WCAP))
            w_eff = abd_pkg::DIM_W'(WCAP);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = abd_pkg::DIM_W'(1);
        else if (height_reg > abd_pkg::DIM_W'(abd_pkg::HEIGHT_LIMIT))
            h_eff = abd_pkg::DIM_W'(abd_pkg::HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    // Classify the current source position
    always_comb
    begin
        col_x = CW'(col_reg);
        row_x = CW'(row_reg);
        sc_x  = CW'(sub_col_reg);
        sr_x  = CW'(sub_row_reg);
        f_x   = CW'(f_eff);
        w_x   = CW'(w_eff);
        h_x   = CW'(h_eff);

        last_col = (col_x + CW'(1)) >= w_x;
        last_row = (row_x + CW'(1)) >= h_x;

        // a block is whole when its start column/row plus the factor fits
        col_in   = (col_x - sc_x + f_x) <= w_x;
        row_in   = (row_x - sr_x + f_x) <= h_x;
        in_block = (f_eff != FW'(1)) && col_in && row_in;

        blk_last      = (FW'(sub_col_reg) == f_eff - FW'(1))
                     && (FW'(sub_row_reg) == f_eff - FW'(1));
        // no further whole block to the right / below
        blk_row_end   = (col_x + f_x + CW'(1)) > w_x;
        blk_frame_end = (row_x + f_x + CW'(1)) > h_x;
    end

    // Drive the per-pixel control
    always_comb
    begin
        ctl.bypass = (f_eff == FW'(1));
        ctl.acc    = in_block;
        ctl.first  = (sub_row_reg == '0) && (sub_col_reg == '0);
        if (f_eff == FW'(1))
        begin
            ctl.emit      = 1'b1;
            ctl.row_end   = last_col;
            ctl.frame_end = last_col && last_row;
        end
        else
        begin
            ctl.emit      = in_block && blk_last;
            ctl.row_end   = blk_row_end;
            ctl.frame_end = blk_row_end && blk_frame_end;
        end
    end

    assign addr   = bc_reg;
    assign factor = f_eff;

    assign cfg_hit = cfg_we && (cfg_index == abd_pkg::REG_SCALE_FACTOR
                             || cfg_index == abd_pkg::REG_SOURCE_WIDTH
                             || cfg_index == abd_pkg::REG_SOURCE_HEIGHT);

    // Take register writes
    always_comb
    begin
        factor_next = factor_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                abd_pkg::REG_SCALE_FACTOR:  factor_next = cfg_data[FW-1:0];
                abd_pkg::REG_SOURCE_WIDTH:  width_next  = cfg_data;
                abd_pkg::REG_SOURCE_HEIGHT: height_next = cfg_data;
                default:                    factor_next = factor_reg;
            endcase
        end
    end

    // Advance the raster and block position; restart on a register write
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        bc_next      = bc_reg;
        if (cfg_hit)
        begin
            col_next     = '0;
            row_next     = '0;
            sub_col_next = '0;
            sub_row_next = '0;
            bc_next      = '0;
        end
        else if (advance)
        begin
            if (in_block)
            begin
                if ((FW'(sub_col_reg) + FW'(1)) >= f_eff)
                begin
                    sub_col_next = '0;
                    bc_next      = bc_reg + 1'b1;
                end
                else
                begin
                    sub_col_next = sub_col_reg + 1'b1;
                end
            end
            if (last_col)
            begin
                col_next     = '0;
                sub_col_next = '0;
                bc_next      = '0;
                if (last_row)
                begin
                    row_next     = '0;
                    sub_row_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    if ((FW'(sub_row_reg) + FW'(1)) >= f_eff)
                        sub_row_next = '0;
                    else
                        sub_row_next = sub_row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Hold registers and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg  <= abd_pkg::FACTOR_RESET;
            width_reg   <= abd_pkg::WIDTH_RESET;
            height_reg  <= abd_pkg::HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            bc_reg      <= '0;
        end
        else
        begin
            factor_reg  <= factor_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            bc_reg      <= bc_next;
        end
    end

    // Position inside a block stays below the factor
    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        (FW'(sub_col_reg) < f_eff) && (FW'(sub_row_reg) < f_eff))
        else $error("block position outside the block");

    // The last result of a frame also closes its row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ctl.emit && ctl.frame_end |-> ctl.row_end)
        else $error("frame end without row end");

endmodule

// ===== hdl/abd_accum.sv =====
// ============================================================================
// abd_accum - line-store accumulate and block average
// Reads the column sum on accept, adds the pixel in the next cycle and writes
// it back, forwarding the previous write when the same entry is reused.
// A second stage scales the finished sum by the reciprocal of f*f, or passes a bypass pixel through.
// ============================================================================
module abd_accum #(
    parameter int LINE_DEPTH = abd_pkg::MAX_SOURCE_WIDTH_DEF / 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_fire,
    input  logic [abd_pkg::PIX_W-1:0]          in_pixel,
    input  abd_pkg::abd_ctl_t                  in_ctl,
    input  logic [$clog2(LINE_DEPTH)-1:0]      in_addr,
    input  logic [abd_pkg::FACTOR_W-1:0]       factor,
    output logic                               push,
    output abd_pkg::abd_res_t                  res,
    output logic [1:0]                         inflight
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int LW = abd_pkg::LINE_W;
    localparam int SW = abd_pkg::SUM_W;
    localparam int CH = abd_pkg::CH_W;
    localparam int PW = abd_pkg::PROD_W;

    // Stage 1: read-modify-write
    logic                           s1_valid_reg;
    abd_pkg::abd_ctl_t              s1_ctl_reg;
    logic [abd_pkg::PIX_W-1:0]      s1_pix_reg;
    logic [AW-1:0]                  s1_addr_reg;

    // Write forwarding
    logic                           fwd_valid_reg;
    logic [AW-1:0]                  fwd_addr_reg;
    logic [LW-1:0]                  fwd_data_reg;

    // Stage 2: scale
    logic                           s2_valid_reg;
    logic                           s2_bypass_reg;
    logic                           s2_row_end_reg;
    logic                           s2_frame_end_reg;
    logic [LW-1:0]                  s2_data_reg;
    logic [abd_pkg::RECIP_W-1:0]    s2_recip_reg;

    logic [LW-1:0]                  rdata;
    logic [LW-1:0]                  base;
    logic [LW-1:0]                  add;
    logic [LW-1:0]                  sum;
    logic                           ram_we;
    logic [PW-1:0]                  prod [abd_pkg::NUM_CH];
    logic [abd_pkg::PIX_W-1:0]      quot;

    abd_ram #(
        .WIDTH (LW),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (sum),
        .re    (in_fire && in_ctl.acc),
        .raddr (in_addr),
        .rdata (rdata)
    );

    // Spread the pixel into channel sums and add to the stored column sum
    always_comb
    begin
        base = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rdata;
        for (int k = 0; k < abd_pkg::NUM_CH; k++)
        begin
            add[k*SW +: SW] = SW'(s1_pix_reg[k*CH +: CH]);
            if (s1_ctl_reg.first)
                sum[k*SW +: SW] = add[k*SW +: SW];
            else
                sum[k*SW +: SW] = base[k*SW +: SW] + add[k*SW +: SW];
        end
    end

    assign ram_we = s1_valid_reg && s1_ctl_reg.acc;

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_fire;
            fwd_valid_reg <= ram_we;
            s2_valid_reg  <= s1_valid_reg && s1_ctl_reg.emit;
        end
    end

    // Hold stage payloads
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ctl_reg  <= in_ctl;
            s1_pix_reg  <= in_pixel;
            s1_addr_reg <= in_addr;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= sum;
        end
        if (s1_valid_reg && s1_ctl_reg.emit)
        begin
            s2_bypass_reg    <= s1_ctl_reg.bypass;
            s2_row_end_reg   <= s1_ctl_reg.row_end;
            s2_frame_end_reg <= s1_ctl_reg.frame_end;
            s2_data_reg      <= s1_ctl_reg.bypass ? LW'(s1_pix_reg) : sum;
            s2_recip_reg     <= abd_pkg::abd_recip(factor);
        end
    end

    // Divide each channel sum by f*f through the reciprocal
    always_comb
    begin
        for (int k = 0; k < abd_pkg::NUM_CH; k++)
        begin
            prod[k] = PW'(s2_data_reg[k*SW +: SW]) * PW'(s2_recip_reg);
            quot[k*CH +: CH] = prod[k][abd_pkg::RECIP_SHIFT +: CH];
        end
    end

    assign push               = s2_valid_reg;
    assign res.averaged_pixel = s2_bypass_reg ? s2_data_reg[abd_pkg::PIX_W-1:0] : quot;
    assign res.row_end        = s2_row_end_reg;
    assign res.frame_end      = s2_frame_end_reg;
    assign inflight           = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

    // A result in the scale stage came from an emitting request
    a_s2_origin: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg && s1_ctl_reg.emit))
        else $error("scale stage loaded without an emitting request");

endmodule

// ===== hdl/abd_ofifo.sv =====
// ============================================================================
// abd_ofifo - result queue
// Small register queue between the scale stage and the result channel;
// its fill level feeds the input credit check.
// ============================================================================
module abd_ofifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  abd_pkg::abd_res_t                 push_data,
    abd_res_if.source                         results,
    output logic [abd_pkg::OUT_CNT_W-1:0]     count
);

    localparam int PTRW = abd_pkg::OUT_PTR_W;
    localparam int CNTW = abd_pkg::OUT_CNT_W;

    abd_pkg::abd_res_t    slot_reg [abd_pkg::OUT_DEPTH];
    logic [PTRW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]      count_reg, count_next;
    logic                 pop;
    abd_pkg::abd_res_t    head;

    assign head                   = slot_reg[rd_ptr_reg];
    assign results.valid          = (count_reg != '0);
    assign results.averaged_pixel = head.averaged_pixel;
    assign results.row_end        = head.row_end;
    assign results.frame_end      = head.frame_end;
    assign pop                    = results.valid && results.ready;
    assign count                  = count_reg;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Credit check upstream must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNTW'(abd_pkg::OUT_DEPTH)) || pop)
        else $error("result queue overflow");

endmodule

// ===== hdl/argb_box_downsampler.sv =====
// ============================================================================
// argb_box_downsampler - integer-factor box filter for ARGB pixel streams
// Top level: registers and position, line-store accumulator, result queue.
// ============================================================================
// Source pixels arrive in raster order; each output pixel is the per-channel
// floor average of a factor-by-factor block and goes through the accumulate and
// scale stages into the result queue after the bottom-right pixel of its block
// is taken (a factor of one passes pixels through on the same path). While ready
// is high, the block takes one pixel per clock: the column sums live in a single
// line store with one read and one write port, read when a pixel is taken and
// written back the next cycle, with the previous write forwarded when neighboring
// pixels hit the same column sum. Ready drops once the results waiting in the
// four-entry result queue plus the requests still in the two pipeline stages add
// up to four, so with the result side stalled, input continues until four results
// are waiting. The line store needs no clearing pass; every sum starts fresh at
// the top left pixel of its block. A write to any register restarts the frame and
// must be made while no pixel is in flight.
// ============================================================================
module argb_box_downsampler #(
    parameter int MAX_SOURCE_WIDTH = abd_pkg::MAX_SOURCE_WIDTH_DEF,
    parameter int MAX_FACTOR       = abd_pkg::MAX_FACTOR_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    abd_pix_if.sink                          pixels,
    abd_res_if.source                        results,
    input  logic                             cfg_we,
    input  logic [abd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [abd_pkg::DIM_W-1:0]        cfg_data
);

    localparam int LINE_DEPTH = MAX_SOURCE_WIDTH / 2;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int CNTW       = abd_pkg::OUT_CNT_W;

    abd_pkg::abd_ctl_t                 ctl;
    logic [AW-1:0]                     addr;
    logic [abd_pkg::FACTOR_W-1:0]      factor;
    logic                              in_fire;
    logic                              push;
    abd_pkg::abd_res_t                 res;
    logic [1:0]                        inflight;
    logic [CNTW-1:0]                   queue_count;
    logic [CNTW-1:0]                   occupancy;

    // Accept a request only when its result is sure to find room
    assign occupancy    = queue_count + CNTW'(inflight);
    assign pixels.ready = occupancy < CNTW'(abd_pkg::OUT_DEPTH);
    assign in_fire      = pixels.valid && pixels.ready;

    abd_ctrl #(
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
        .MAX_FACTOR       (MAX_FACTOR)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_fire),
        .ctl       (ctl),
        .addr      (addr),
        .factor    (factor)
    );

    abd_accum #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_pixel (pixels.source_pixel),
        .in_ctl   (ctl),
        .in_addr  (addr),
        .factor   (factor),
        .push     (push),
        .res      (res),
        .inflight (inflight)
    );

    abd_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .results   (results),
        .count     (queue_count)
    );

endmodule

// ===== tb/sv/argb_box_downsampler_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// argb_box_downsampler_test - self-checking bench for the ARGB box downsampler
// Streams ARGB pixel requests through the block under many factor and frame
// settings, predicts every block average with row and frame markers, and
// compares each result in order. Random sender bursts and result stalls.
// ============================================================================
module argb_box_downsampler_test;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_PAD    = 8;
    localparam int END_PAD      = 16;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int RANDOM_ITEMS = 350;
    localparam int LINE_ENTRIES = abd_pkg::MAX_SOURCE_WIDTH_DEF / 2;
    localparam logic [abd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_RHYTHM, RX_LONG} rx_pattern_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [abd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [abd_pkg::DIM_W-1:0]     cfg_data;

    abd_pix_if pixels ();
    abd_res_if results ();

    argb_box_downsampler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow registers and position of the downsampler
    logic [abd_pkg::FACTOR_W-1:0] factor_reg;
    logic [abd_pkg::DIM_W-1:0]    width_reg;
    logic [abd_pkg::DIM_W-1:0]    height_reg;
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    int unsigned                  sub_col;
    int unsigned                  sub_row;
    int unsigned                  blk_col;
    logic [abd_pkg::LINE_W-1:0]   column_sums [0:LINE_ENTRIES-1];

    abd_pkg::abd_res_t awaited_averages[$];

    int error_count     = 0;
    int pixels_sent     = 0;
    int random_pixels   = 0;
    int averages_seen   = 0;
    int reg_writes      = 0;
    int cycles_run      = 0;
    int burst_left      = 0;

    rx_pattern_t rx_pattern = RX_ALWAYS;
    int          rx_left    = 0;
    int          hold_left  = 0;
    logic        hold_high  = 1'b1;

    function automatic int unsigned clamp_setting(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [abd_pkg::PIX_W-1:0] pick_pixel();
        logic [abd_pkg::PIX_W-1:0] p;
        int k;
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = '1;
            2:
            begin
                for (k = 0; k < abd_pkg::NUM_CH; k++)
                    p[abd_pkg::CH_W*k +: abd_pkg::CH_W] =
                        ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
            default: p = $urandom;
        endcase
        return p;
    endfunction

    // Return to the first pixel of a frame
    task automatic restart_position();
        col_pos = 0;
        row_pos = 0;
        sub_col = 0;
        sub_row = 0;
        blk_col = 0;
    endtask

    // Mirror one register write; unlisted indexes change nothing
    task automatic apply_register(input logic [abd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [abd_pkg::DIM_W-1:0] data);
        case (idx)
            abd_pkg::REG_SCALE_FACTOR:  factor_reg = data[abd_pkg::FACTOR_W-1:0];
            abd_pkg::REG_SOURCE_WIDTH:  width_reg  = data;
            abd_pkg::REG_SOURCE_HEIGHT: height_reg = data;
            default:                    return;
        endcase
        restart_position();
    endtask

    // Accumulate one accepted pixel and queue the block average it completes
    task automatic reduce_pixel(input logic [abd_pkg::PIX_W-1:0] pix);
        int unsigned       f, w, h, ow, oh, s;
        int                k;
        logic              last_col, last_row, in_blk;
        abd_pkg::abd_res_t r;
        f = clamp_setting(32'(factor_reg), abd_pkg::MAX_FACTOR_DEF);
        w = clamp_setting(32'(width_reg), abd_pkg::MAX_SOURCE_WIDTH_DEF);
        h = clamp_setting(32'(height_reg), abd_pkg::HEIGHT_LIMIT);
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        r = '0;
        if (f == 1)
        begin
            r.averaged_pixel = pix;
            r.row_end        = last_col;
            r.frame_end      = last_col && last_row;
            awaited_averages.push_back(r);
        end
        else
        begin
            ow = w / f;
            oh = h / f;
            in_blk = (col_pos < ow * f) && (row_pos < oh * f);
            if (in_blk)
            begin
                for (k = 0; k < abd_pkg::NUM_CH; k++)
                begin
                    s = 32'(pix[abd_pkg::CH_W*k +: abd_pkg::CH_W]);
                    if (sub_row != 0 || sub_col != 0)
                        s += 32'(column_sums[blk_col][abd_pkg::SUM_W*k +: abd_pkg::SUM_W]);
                    column_sums[blk_col][abd_pkg::SUM_W*k +: abd_pkg::SUM_W] =
                        s[abd_pkg::SUM_W-1:0];
                    r.averaged_pixel[abd_pkg::CH_W*k +: abd_pkg::CH_W] =
                        abd_pkg::CH_W'(32'(s[abd_pkg::SUM_W-1:0]) / (f * f));
                end
                if (sub_row == f - 1 && sub_col == f - 1)
                begin
                    r.row_end   = (blk_col == ow - 1);
                    r.frame_end = r.row_end && (row_pos == oh * f - 1);
                    awaited_averages.push_back(r);
                end
                sub_col++;
                if (sub_col >= f)
                begin
                    sub_col = 0;
                    blk_col = (blk_col + 1) & 32'h7FF;
                end
            end
        end
        // Advance the raster position
        if (last_col)
        begin
            col_pos = 0;
            sub_col = 0;
            blk_col = 0;
            if (last_row)
            begin
                row_pos = 0;
                sub_row = 0;
            end
            else
            begin
                row_pos++;
                sub_row++;
                if (sub_row >= f)
                    sub_row = 0;
            end
        end
        else
            col_pos++;
    endtask

    // Send one pixel request, with random gaps between bursts
    task automatic send_pixel(input logic [abd_pkg::PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                pixels.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixels.valid        <= 1'b1;
        pixels.source_pixel <= pix;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
        reduce_pixel(pix);
        pixels_sent++;
    endtask

    // Hold input until every pending average has arrived, then let the pipe empty
    task automatic drain_results();
        pixels.valid <= 1'b0;
        while (awaited_averages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [abd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [abd_pkg::DIM_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(posedge clk);
        apply_register(idx, data);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Write all three registers, starting from a random one, while the block is idle
    task automatic configure(input logic [abd_pkg::DIM_W-1:0] factor_raw,
                             input logic [abd_pkg::DIM_W-1:0] width_raw,
                             input logic [abd_pkg::DIM_W-1:0] height_raw);
        int start, i;
        drain_results();
        start = $urandom_range(0, 2);
        for (i = 0; i < 3; i++)
        begin
            case ((start + i) % 3)
                0:       write_reg(abd_pkg::REG_SCALE_FACTOR, factor_raw);
                1:       write_reg(abd_pkg::REG_SOURCE_WIDTH, width_raw);
                default: write_reg(abd_pkg::REG_SOURCE_HEIGHT, height_raw);
            endcase
        end
    endtask

    task automatic send_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_pixel(pick_pixel());
    endtask

    // Defaults after reset: pass-through on a 640-wide frame
    task automatic test_reset_values();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hA5A5_A5A5);
        send_pixel(32'h5A5A_5A5A);
    endtask

    // Factor one: pixels unchanged, row and frame markers, frame wrap
    task automatic test_passthrough();
        logic [abd_pkg::PIX_W-1:0] seq [9] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                               32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555,
                                               32'h00FF_00FF, 32'hFF00_FF00, 32'h1234_5678};
        int i;
        configure(1, 3, 2);
        for (i = 0; i < 9; i++)
            send_pixel(seq[i]);
    endtask

    // Factor above the limit acts as the largest one; full-scale channel sums
    task automatic test_full_scale_block();
        int i;
        configure(13'h1FFF, 16, 16);
        for (i = 0; i < 256; i++)
            send_pixel(32'hFFFF_FFFF);
    endtask

    // Trailing columns and rows outside whole blocks are dropped
    task automatic test_partial_blocks();
        configure(3, 7, 7);
        send_random(98);
        configure(2, 5, 3);
        send_random(30);
    endtask

    // Out-of-range settings clamp; images smaller than a block give nothing
    task automatic test_out_of_range();
        configure(0, 0, 0);
        send_random(3);
        configure(2, 13'h1FFF, 0);
        send_random(20);
        configure(5, 4, 9);
        send_random(40);
    endtask

    // Unlisted index keeps the frame going; a listed one restarts it
    task automatic test_register_writes();
        configure(2, 4, 4);
        send_random(6);
        drain_results();
        write_reg(REG_UNUSED, abd_pkg::DIM_W'($urandom_range(0, 8191)));
        send_random(10);
        send_random(5);
        drain_results();
        write_reg(abd_pkg::REG_SCALE_FACTOR, 2);
        send_random(16);
    endtask

    // Long line: a hundred column sums carried across one block row
    task automatic test_wide_line();
        configure(2, 200, 2);
        send_random(400);
    endtask

    // Height above the limit with one column: a row end on every pixel
    task automatic test_tall_frame();
        configure(1, 1, 13'h1FFF);
        send_random(40);
    endtask

    // Random settings, mostly whole frames plus stray pixels
    task automatic test_random_frames();
        logic [abd_pkg::DIM_W-1:0] fraw, wraw, hraw;
        int unsigned               f, kmax, count, frame_px;
        int                        i;
        while (random_pixels < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       fraw = '0;
                1:       fraw = abd_pkg::DIM_W'($urandom_range(17, 31)
                                                | ($urandom_range(0, 255) << 5));
                2:       fraw = abd_pkg::DIM_W'(16);
                default: fraw = abd_pkg::DIM_W'($urandom_range(1, 6));
            endcase
            f = clamp_setting(32'(fraw[abd_pkg::FACTOR_W-1:0]), abd_pkg::MAX_FACTOR_DEF);
            kmax = (f <= 2) ? 5 : ((f <= 4) ? 3 : ((f <= 8) ? 2 : 1));
            if ($urandom_range(0, 19) == 0)
            begin
                wraw = abd_pkg::DIM_W'($urandom_range(4097, 8191));
                hraw = abd_pkg::DIM_W'($urandom_range(0, 3));
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                wraw = abd_pkg::DIM_W'($urandom_range(0, 24));
                hraw = abd_pkg::DIM_W'($urandom_range(0, 24));
            end
            else
            begin
                wraw = abd_pkg::DIM_W'(f * $urandom_range(1, kmax) + $urandom_range(0, f - 1));
                hraw = abd_pkg::DIM_W'(f * $urandom_range(1, kmax) + $urandom_range(0, f - 1));
            end
            configure(fraw, wraw, hraw);
            frame_px = clamp_setting(32'(wraw), abd_pkg::MAX_SOURCE_WIDTH_DEF)
                       * clamp_setting(32'(hraw), abd_pkg::HEIGHT_LIMIT);
            count = frame_px * $urandom_range(1, 2) + $urandom_range(0, 7);
            if (count > 300)
                count = $urandom_range(50, 200);
            for (i = 0; i < count; i++)
            begin
                // Pause mid-stream now and then until all averages are in
                if (i == count / 2 && $urandom_range(0, 3) == 0)
                    drain_results();
                send_pixel(pick_pixel());
                random_pixels++;
            end
        end
    endtask

    // Result side: stall on a changing pattern of its own
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            rx_left    = $urandom_range(50, 400);
        end
        rx_left--;
        case (rx_pattern)
            RX_ALWAYS: results.ready <= 1'b1;
            RX_COIN:   results.ready <= ($urandom_range(0, 1) == 1);
            RX_RHYTHM: results.ready <= (cycles_run % 5) != 0;
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_left = $urandom_range(2, 24);
                    hold_high = ~hold_high;
                end
                hold_left--;
                results.ready <= hold_high;
            end
        endcase
    end

    // Compare each accepted result with the oldest pending average
    always @(posedge clk)
    begin
        abd_pkg::abd_res_t want;
        if (rst_n && results.valid && results.ready)
        begin
            averages_seen++;
            if (awaited_averages.size() == 0)
            begin
                $error("averaged_pixel %08h arrived with none pending",
                       results.averaged_pixel);
                error_count++;
            end
            else
            begin
                want = awaited_averages.pop_front();
                if (results.averaged_pixel !== want.averaged_pixel)
                begin
                    $error("averaged_pixel: expected %08h, got %08h",
                           want.averaged_pixel, results.averaged_pixel);
                    error_count++;
                end
                if (results.row_end !== want.row_end)
                begin
                    $error("row_end: expected %0b, got %0b", want.row_end, results.row_end);
                    error_count++;
                end
                if (results.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b",
                           want.frame_end, results.frame_end);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        while (cycles_run < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $error("run stopped after %0d cycles with %0d averages pending",
               cycles_run, awaited_averages.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = abd_pkg::REG_SCALE_FACTOR;
        cfg_data            = '0;
        pixels.valid        = 1'b0;
        pixels.source_pixel = '0;
        factor_reg          = abd_pkg::FACTOR_RESET;
        width_reg           = abd_pkg::WIDTH_RESET;
        height_reg          = abd_pkg::HEIGHT_RESET;
        restart_position();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_passthrough();
        test_full_scale_block();
        test_partial_blocks();
        test_out_of_range();
        test_register_writes();
        test_wide_line();
        test_tall_frame();
        test_random_frames();

        pixels.valid <= 1'b0;
        while (awaited_averages.size() != 0)
            @(posedge clk);
        repeat (END_PAD) @(posedge clk);

        $display("Fed %0d source pixels under %0d register writes (factors 1 to 16).",
                 pixels_sent, reg_writes);
        $display("Compared %0d output pixels in %0d cycles, %0d mismatches.",
                 averages_seen, cycles_run, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
